// ----- rtl/pingpong_delay_and_comb_reverb_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ping-pong delay and comb reverb core
// Same-cycle-implication and next-cycle-implication checks on i_clk.
// ----------------------------------------------------------------------------
`ifndef PINGPONG_DELAY_AND_COMB_REVERB_CORE_DEFINES_SVH
`define PINGPONG_DELAY_AND_COMB_REVERB_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, disabled in reset
`define PDCR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pdcr assertion failed");
// Next-cycle implication, disabled in reset
`define PDCR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pdcr assertion failed");
`else
`define PDCR_ASSERT_IMP(lbl, ante, cons)
`define PDCR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/pdcr_pkg.sv -----
// ----------------------------------------------------------------------------
// pdcr_pkg
// Shared constants, command/status types and helper functions of the core.
// ----------------------------------------------------------------------------
package pdcr_pkg;

    localparam int P_MAX_DELAY   = 65536;
    localparam int P_NUM_COMBS   = 8;
    localparam int P_NUM_ALLPASS = 4;

    localparam int COMB_SLOT = 1100;
    localparam int AP_SLOT   = 300;
    localparam int SPREAD    = 23;
    localparam int MIN_DELAY = 32;

    localparam int SMP_W     = 16;
    localparam int SEND_W    = 31;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int UNIT_W    = 4;
    localparam int CB_IDX_W  = 11;
    localparam int AP_IDX_W  = 9;
    localparam int DAMP_W    = 24;
    localparam int OP_W      = 4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_FB  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DAMP      = 2'd3;

    localparam logic [CFG_W-1:0] RST_DELAY_LEN = 17'd11025;
    localparam logic [7:0]       RST_DELAY_FB  = 8'd140;
    localparam logic [7:0]       RST_SIZE      = 8'd160;
    localparam logic [7:0]       RST_DAMP      = 8'd110;
    localparam logic [7:0]       FB_MAX        = 8'd250;
    localparam logic [7:0]       RFB_BASE      = 8'd179;
    localparam logic [6:0]       RFB_SPAN      = 7'd72;

    localparam logic signed [10:0] DIF_GAIN  = 11'sd640;
    localparam logic signed [31:0] FULL_Q15  = 32'sd1073709056;
    localparam logic signed [16:0] OUT_LIMIT = 17'sd32767;

    // Datapath operations
    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_NONE = 4'd0;
    localparam t_op OP_CLR  = 4'd1;
    localparam t_op OP_LOAD = 4'd2;
    localparam t_op OP_DWR  = 4'd3;
    localparam t_op OP_SIDE = 4'd4;
    localparam t_op OP_CRD  = 4'd5;
    localparam t_op OP_CMUL = 4'd6;
    localparam t_op OP_CST  = 4'd7;
    localparam t_op OP_CWR  = 4'd8;
    localparam t_op OP_DIF  = 4'd9;
    localparam t_op OP_ARD  = 4'd10;
    localparam t_op OP_AWR  = 4'd11;
    localparam t_op OP_HOLD = 4'd12;
    localparam t_op OP_OUT  = 4'd13;

    typedef struct packed {
        t_op               op;
        logic              side;
        logic [UNIT_W-1:0] unit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic phase;
        logic out_free;
    } t_stat;

    // Comb line length for a side and comb number
    function automatic logic [CB_IDX_W-1:0] comb_len(input logic side,
                                                     input logic [UNIT_W-1:0] c);
        logic [11:0] base;
        logic [11:0] sum;
        case (c)
            4'd0:    base = 12'd1116;
            4'd1:    base = 12'd1188;
            4'd2:    base = 12'd1277;
            4'd3:    base = 12'd1356;
            4'd4:    base = 12'd1422;
            4'd5:    base = 12'd1491;
            4'd6:    base = 12'd1557;
            4'd7:    base = 12'd1617;
            4'd8:    base = 12'd1687;
            4'd9:    base = 12'd1753;
            4'd10:   base = 12'd1823;
            4'd11:   base = 12'd1889;
            4'd12:   base = 12'd1949;
            4'd13:   base = 12'd2011;
            4'd14:   base = 12'd2081;
            default: base = 12'd2143;
        endcase
        sum = base + (side ? 12'(SPREAD) : 12'd0);
        return sum[CB_IDX_W:1];
    endfunction

    // Allpass line length for a side and allpass number
    function automatic logic [AP_IDX_W-1:0] ap_len(input logic side,
                                                   input logic [UNIT_W-1:0] a);
        logic [9:0] base;
        logic [9:0] sum;
        case (a[2:0])
            3'd0:    base = 10'd556;
            3'd1:    base = 10'd441;
            3'd2:    base = 10'd341;
            3'd3:    base = 10'd225;
            3'd4:    base = 10'd181;
            3'd5:    base = 10'd143;
            3'd6:    base = 10'd113;
            default: base = 10'd89;
        endcase
        sum = base + (side ? 10'(SPREAD) : 10'd0);
        return sum[AP_IDX_W:1];
    endfunction

    // Comb feedback 179 + size*72/255; division by 255 via reciprocal trick
    function automatic logic [7:0] rfb_of(input logic [7:0] size);
        logic [15:0] v;
        logic [15:0] q;
        v = 16'(size) * 16'(RFB_SPAN) + 16'd1;
        q = (v + (v >> 8)) >> 8;
        return RFB_BASE + q[7:0];
    endfunction

    // Saturate to a 16-bit sample
    function automatic logic signed [SMP_W-1:0] sat16(input logic signed [39:0] v);
        if (v > 40'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -40'sd32768) begin
            return 16'sh8000;
        end
        return v[SMP_W-1:0];
    endfunction

    // Saturate the wet return to +/-32767
    function automatic logic signed [SMP_W-1:0] sat_out(input logic signed [16:0] v);
        if (v > OUT_LIMIT) begin
            return 16'sd32767;
        end else if (v < -OUT_LIMIT) begin
            return -16'sd32767;
        end
        return v[SMP_W-1:0];
    endfunction

endpackage

// ----- rtl/pdcr_ctrl.sv -----
// ----------------------------------------------------------------------------
// pdcr_ctrl
// Sequencer: clearing pass, delay step, half-rate comb/allpass walk, output.
// ----------------------------------------------------------------------------
module pdcr_ctrl import pdcr_pkg::*; #(
    parameter int NUM_COMBS   = P_NUM_COMBS,
    parameter int NUM_ALLPASS = P_NUM_ALLPASS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_DWR  = 4'd2;
    localparam logic [3:0] S_SIDE = 4'd3;
    localparam logic [3:0] S_CRD  = 4'd4;
    localparam logic [3:0] S_CMUL = 4'd5;
    localparam logic [3:0] S_CST  = 4'd6;
    localparam logic [3:0] S_CWR  = 4'd7;
    localparam logic [3:0] S_DIF  = 4'd8;
    localparam logic [3:0] S_ARD  = 4'd9;
    localparam logic [3:0] S_AWR  = 4'd10;
    localparam logic [3:0] S_HOLD = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    localparam logic [UNIT_W-1:0] LAST_COMB = UNIT_W'(NUM_COMBS - 1);
    localparam logic [UNIT_W-1:0] LAST_AP   = UNIT_W'(NUM_ALLPASS - 1);

    logic [3:0]        r_state, n_state;
    logic              r_side, n_side;
    logic [UNIT_W-1:0] r_unit, n_unit;

    // Next state and counters
    always_comb begin
        n_state = r_state;
        n_side  = r_side;
        n_unit  = r_unit;
        case (r_state)
            S_CLR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_DWR;
            end
            S_DWR: begin
                n_side  = 1'b0;
                n_state = i_stat.phase ? S_SIDE : S_OUT;
            end
            S_SIDE: begin
                n_unit  = '0;
                n_state = S_CRD;
            end
            S_CRD:  n_state = S_CMUL;
            S_CMUL: n_state = S_CST;
            S_CST:  n_state = S_CWR;
            S_CWR: begin
                if (r_unit == LAST_COMB) begin
                    n_unit  = '0;
                    n_state = S_DIF;
                end else begin
                    n_unit  = r_unit + 1'b1;
                    n_state = S_CRD;
                end
            end
            S_DIF:  n_state = S_ARD;
            S_ARD:  n_state = S_AWR;
            S_AWR: begin
                if (r_unit == LAST_AP) begin
                    n_state = S_HOLD;
                end else begin
                    n_unit  = r_unit + 1'b1;
                    n_state = S_ARD;
                end
            end
            S_HOLD: begin
                if (r_side) begin
                    n_state = S_OUT;
                end else begin
                    n_side  = 1'b1;
                    n_state = S_SIDE;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLR;
        endcase
    end

    // Issue the datapath command for the current state
    always_comb begin
        o_cmd.side = r_side;
        o_cmd.unit = r_unit;
        case (r_state)
            S_CLR:   o_cmd.op = OP_CLR;
            S_IDLE:  o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_DWR:   o_cmd.op = OP_DWR;
            S_SIDE:  o_cmd.op = OP_SIDE;
            S_CRD:   o_cmd.op = OP_CRD;
            S_CMUL:  o_cmd.op = OP_CMUL;
            S_CST:   o_cmd.op = OP_CST;
            S_CWR:   o_cmd.op = OP_CWR;
            S_DIF:   o_cmd.op = OP_DIF;
            S_ARD:   o_cmd.op = OP_ARD;
            S_AWR:   o_cmd.op = OP_AWR;
            S_HOLD:  o_cmd.op = OP_HOLD;
            S_OUT:   o_cmd.op = i_stat.out_free ? OP_OUT : OP_NONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_side  <= 1'b0;
            r_unit  <= '0;
        end else begin
            r_state <= n_state;
            r_side  <= n_side;
            r_unit  <= n_unit;
        end
    end

endmodule

// ----- rtl/pdcr_datapath.sv -----
// ----------------------------------------------------------------------------
// pdcr_datapath
// Delay lines, comb and allpass stores, shared arithmetic, config and output.
// ----------------------------------------------------------------------------
module pdcr_datapath import pdcr_pkg::*; #(
    parameter int MAX_DELAY   = P_MAX_DELAY,
    parameter int NUM_COMBS   = P_NUM_COMBS,
    parameter int NUM_ALLPASS = P_NUM_ALLPASS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic signed [SEND_W-1:0] i_delay_send_left,
    input  logic signed [SEND_W-1:0] i_delay_send_right,
    input  logic signed [SEND_W-1:0] i_reverb_send_left,
    input  logic signed [SEND_W-1:0] i_reverb_send_right,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic signed [SMP_W-1:0]  o_out_left,
    output logic signed [SMP_W-1:0]  o_out_right
);

    localparam int LEN_W     = $clog2(MAX_DELAY + 1);
    localparam int DIDX_W    = $clog2(MAX_DELAY);
    localparam int NK_C      = 2 * NUM_COMBS;
    localparam int KC_W      = $clog2(NK_C);
    localparam int CB_DEPTH  = NK_C * COMB_SLOT;
    localparam int CB_AW     = $clog2(CB_DEPTH);
    localparam int NK_A      = 2 * NUM_ALLPASS;
    localparam int KA_W      = $clog2(NK_A);
    localparam int AP_DEPTH  = NK_A * AP_SLOT;
    localparam int AP_AW     = $clog2(AP_DEPTH);
    localparam int ACC_W     = SMP_W + $clog2(NUM_COMBS) + 1;
    localparam int CLR_DEPTH = (MAX_DELAY > CB_DEPTH) ?
                               ((MAX_DELAY > AP_DEPTH) ? MAX_DELAY : AP_DEPTH) :
                               ((CB_DEPTH > AP_DEPTH) ? CB_DEPTH : AP_DEPTH);
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    // Configuration
    logic [LEN_W-1:0] r_len;
    logic [7:0]       r_fb, r_size, r_damp;
    logic [7:0]       rfb;

    // Control state
    logic [DIDX_W-1:0]   r_didx;
    logic [CB_IDX_W-1:0] r_cidx [NK_C];
    logic [AP_IDX_W-1:0] r_aidx [NK_A];
    logic signed [DAMP_W-1:0] r_damping [NK_C];
    logic                r_phase;
    logic signed [31:0]  r_sum_l, r_sum_r;
    logic signed [SMP_W-1:0] r_held_l, r_held_r;
    logic                r_out_valid;
    logic [CLR_W-1:0]    r_clr;

    // Payload registers
    logic signed [SEND_W-1:0] r_ds_l, r_ds_r, r_rs_l, r_rs_r;
    logic signed [SMP_W-1:0]  r_tap_l, r_tap_r;
    logic signed [31:0]       r_avg_l, r_avg_r;
    logic signed [16:0]       r_in;
    logic [CB_IDX_W-1:0]      r_p;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [25:0]       r_m1;
    logic signed [32:0]       r_m2, r_m3;
    logic signed [SMP_W-1:0]  r_dif;
    logic signed [SMP_W-1:0]  r_out_l, r_out_r;

    // Memories
    logic [2*SMP_W-1:0] dmem [MAX_DELAY];
    logic [SMP_W-1:0]   cmem [CB_DEPTH];
    logic [SMP_W-1:0]   amem [AP_DEPTH];
    logic [2*SMP_W-1:0] r_drd;
    logic [SMP_W-1:0]   r_cbrd, r_aprd;

    logic                d_we, cb_we, ap_we;
    logic [DIDX_W-1:0]   d_wa;
    logic [2*SMP_W-1:0]  d_wd;
    logic [CB_AW-1:0]    cb_ra, cb_wa;
    logic [SMP_W-1:0]    cb_wd;
    logic [AP_AW-1:0]    ap_ra, ap_wa;
    logic [SMP_W-1:0]    ap_wd;

    // Working signals
    logic [31:0]             cfg32;
    logic [LEN_W-1:0]        cfg_len;
    logic [7:0]              cfg_fb;
    logic [DIDX_W-1:0]       pos_eff, pos_nxt;
    logic [31:0]             pos_inc;
    logic signed [SMP_W-1:0] tap_l, tap_r;
    logic signed [8:0]       fb_s;
    logic signed [24:0]      fbp_l, fbp_r;
    logic signed [SMP_W-1:0] wl, wr;
    logic signed [31:0]      rin_l, rin_r, rinc_l, rinc_r, sum_l, sum_r;
    logic signed [31:0]      avg_s;
    logic signed [16:0]      x;
    logic [8:0]              irfb;
    logic signed [26:0]      inprod;
    logic [31:0]             kc32, ka32;
    logic [KC_W-1:0]         kc;
    logic [KA_W-1:0]         ka;
    logic [CB_IDX_W-1:0]     clen, cidx_cur, cp_eff, cp_nxt;
    logic [AP_IDX_W-1:0]     alen, aidx_cur, ap_eff, ap_nxt;
    logic [31:0]             cp_inc, ap_inc;
    logic signed [SMP_W-1:0] cout, bo;
    logic [8:0]              dinv;
    logic signed [25:0]      m1;
    logic signed [32:0]      m2, m3;
    logic signed [25:0]      st26;
    logic signed [DAMP_W-1:0] st;
    logic signed [ACC_W+10:0] difp;
    logic signed [16:0]      ao, aw, ol, orr;

    assign rfb = rfb_of(r_size);

    // Clamp configuration values
    always_comb begin
        cfg32 = 32'(i_cfg_data);
        if (cfg32 < 32'(MIN_DELAY)) begin
            cfg_len = LEN_W'(MIN_DELAY);
        end else if (cfg32 > 32'(MAX_DELAY)) begin
            cfg_len = LEN_W'(MAX_DELAY);
        end else begin
            cfg_len = LEN_W'(cfg32);
        end
        cfg_fb = (i_cfg_data[7:0] > FB_MAX) ? FB_MAX : i_cfg_data[7:0];
    end

    // Ping-pong delay step
    always_comb begin
        pos_eff = (32'(r_didx) >= 32'(r_len)) ? '0 : r_didx;
        pos_inc = 32'(pos_eff) + 32'd1;
        pos_nxt = (pos_inc >= 32'(r_len)) ? '0 : DIDX_W'(pos_inc);
        tap_l   = $signed(r_drd[2*SMP_W-1:SMP_W]);
        tap_r   = $signed(r_drd[SMP_W-1:0]);
        fb_s    = $signed({1'b0, r_fb});
        fbp_l   = tap_r * fb_s;
        fbp_r   = tap_l * fb_s;
        wl      = sat16(40'(r_ds_l >>> 15) + 40'(fbp_l >>> 8));
        wr      = sat16(40'(r_ds_r >>> 15) + 40'(fbp_r >>> 8));
        rin_l   = 32'(r_rs_l) + (32'(tap_l) <<< 13);
        rin_r   = 32'(r_rs_r) + (32'(tap_r) <<< 13);
        rinc_l  = (rin_l > FULL_Q15) ? FULL_Q15 : ((rin_l < -FULL_Q15) ? -FULL_Q15 : rin_l);
        rinc_r  = (rin_r > FULL_Q15) ? FULL_Q15 : ((rin_r < -FULL_Q15) ? -FULL_Q15 : rin_r);
        sum_l   = r_sum_l + (rinc_l >>> 1);
        sum_r   = r_sum_r + (rinc_r >>> 1);
    end

    // Comb, diffusion, allpass and output-sum arithmetic
    always_comb begin
        avg_s    = i_cmd.side ? r_avg_r : r_avg_l;
        x        = 17'(avg_s >>> 15);
        irfb     = 9'd256 - {1'b0, rfb};
        inprod   = x * $signed({1'b0, irfb});

        kc32     = i_cmd.side ? 32'(NUM_COMBS) + 32'(i_cmd.unit) : 32'(i_cmd.unit);
        ka32     = i_cmd.side ? 32'(NUM_ALLPASS) + 32'(i_cmd.unit) : 32'(i_cmd.unit);
        kc       = KC_W'(kc32);
        ka       = KA_W'(ka32);

        clen     = comb_len(i_cmd.side, i_cmd.unit);
        cidx_cur = r_cidx[kc];
        cp_eff   = (cidx_cur >= clen) ? '0 : cidx_cur;
        cp_inc   = 32'(r_p) + 32'd1;
        cp_nxt   = (cp_inc >= 32'(clen)) ? '0 : CB_IDX_W'(cp_inc);
        cb_ra    = CB_AW'(kc32 * 32'(COMB_SLOT) + 32'(cp_eff));
        cb_wa    = CB_AW'(kc32 * 32'(COMB_SLOT) + 32'(r_p));

        alen     = ap_len(i_cmd.side, i_cmd.unit);
        aidx_cur = r_aidx[ka];
        ap_eff   = (aidx_cur >= alen) ? '0 : aidx_cur;
        ap_inc   = 32'(r_p) + 32'd1;
        ap_nxt   = (ap_inc >= 32'(alen)) ? '0 : AP_IDX_W'(ap_inc);
        ap_ra    = AP_AW'(ka32 * 32'(AP_SLOT) + 32'(ap_eff));
        ap_wa    = AP_AW'(ka32 * 32'(AP_SLOT) + 32'(r_p));

        cout     = $signed(r_cbrd);
        dinv     = 9'd256 - {1'b0, r_damp};
        m1       = cout * $signed({1'b0, dinv});
        m2       = r_damping[kc] * $signed({1'b0, r_damp});
        st26     = 26'(r_m1 >>> 2) + 26'(r_m2 >>> 8);
        st       = st26[DAMP_W-1:0];
        m3       = st * $signed({1'b0, rfb});
        cb_wd    = sat16(40'(r_in) + 40'(r_m3 >>> 14));

        difp     = r_acc * DIF_GAIN;

        bo       = $signed(r_aprd);
        ao       = 17'(bo) - 17'(r_dif);
        aw       = 17'(r_dif) + 17'(bo >>> 1);
        ap_wd    = sat16(40'(aw));

        ol       = 17'(r_tap_l) + 17'(r_held_l);
        orr      = 17'(r_tap_r) + 17'(r_held_r);
    end

    // Memory write selection, clearing pass included
    always_comb begin
        d_we  = ((i_cmd.op == OP_CLR) && (32'(r_clr) < 32'(MAX_DELAY))) ||
                (i_cmd.op == OP_DWR);
        d_wa  = (i_cmd.op == OP_CLR) ? DIDX_W'(r_clr) : pos_eff;
        d_wd  = (i_cmd.op == OP_CLR) ? '0 : {wl, wr};
        cb_we = ((i_cmd.op == OP_CLR) && (32'(r_clr) < 32'(CB_DEPTH))) ||
                (i_cmd.op == OP_CWR);
        ap_we = ((i_cmd.op == OP_CLR) && (32'(r_clr) < 32'(AP_DEPTH))) ||
                (i_cmd.op == OP_AWR);
    end

    always_ff @(posedge i_clk) begin
        if (d_we) dmem[d_wa] <= d_wd;
        r_drd <= dmem[pos_eff];
    end

    always_ff @(posedge i_clk) begin
        if (cb_we) cmem[(i_cmd.op == OP_CLR) ? CB_AW'(r_clr) : cb_wa] <=
            (i_cmd.op == OP_CLR) ? '0 : cb_wd;
        r_cbrd <= cmem[cb_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ap_we) amem[(i_cmd.op == OP_CLR) ? AP_AW'(r_clr) : ap_wa] <=
            (i_cmd.op == OP_CLR) ? '0 : ap_wd;
        r_aprd <= amem[ap_ra];
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= LEN_W'(RST_DELAY_LEN);
            r_fb        <= RST_DELAY_FB;
            r_size      <= RST_SIZE;
            r_damp      <= RST_DAMP;
            r_didx      <= '0;
            for (int i = 0; i < NK_C; i++) begin
                r_cidx[i]    <= '0;
                r_damping[i] <= '0;
            end
            for (int i = 0; i < NK_A; i++) r_aidx[i] <= '0;
            r_phase     <= 1'b0;
            r_sum_l     <= '0;
            r_sum_r     <= '0;
            r_held_l    <= '0;
            r_held_r    <= '0;
            r_out_valid <= 1'b0;
            r_clr       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_DELAY_LEN: begin
                        r_len <= cfg_len;
                        if (32'(r_didx) >= 32'(cfg_len)) r_didx <= '0;
                    end
                    REG_DELAY_FB: r_fb   <= cfg_fb;
                    REG_SIZE:     r_size <= i_cfg_data[7:0];
                    REG_DAMP:     r_damp <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            // Load a new result, or drop the held one once taken
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_CLR: r_clr <= r_clr + 1'b1;
                OP_DWR: begin
                    r_didx  <= pos_nxt;
                    r_phase <= ~r_phase;
                    if (r_phase) begin
                        r_sum_l <= '0;
                        r_sum_r <= '0;
                    end else begin
                        r_sum_l <= sum_l;
                        r_sum_r <= sum_r;
                    end
                end
                OP_CST: r_damping[kc] <= st;
                OP_CWR: r_cidx[kc]    <= cp_nxt;
                OP_AWR: r_aidx[ka]    <= ap_nxt;
                OP_HOLD: begin
                    if (i_cmd.side) r_held_r <= r_dif;
                    else            r_held_l <= r_dif;
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_ds_l <= i_delay_send_left;
                r_ds_r <= i_delay_send_right;
                r_rs_l <= i_reverb_send_left;
                r_rs_r <= i_reverb_send_right;
            end
            OP_DWR: begin
                r_tap_l <= tap_l;
                r_tap_r <= tap_r;
                r_avg_l <= sum_l;
                r_avg_r <= sum_r;
            end
            OP_SIDE: begin
                r_in  <= 17'(inprod >>> 10);
                r_acc <= '0;
            end
            OP_CRD: r_p <= cp_eff;
            OP_CMUL: begin
                r_acc <= r_acc + ACC_W'(cout);
                r_m1  <= m1;
                r_m2  <= m2;
            end
            OP_CST: r_m3  <= m3;
            OP_DIF: r_dif <= sat16(40'(difp >>> 8));
            OP_ARD: r_p   <= CB_IDX_W'(ap_eff);
            OP_AWR: r_dif <= sat16(40'(ao));
            OP_OUT: begin
                r_out_l <= sat_out(ol);
                r_out_r <= sat_out(orr);
            end
            default: ;
        endcase
    end

    assign o_stat.clr_last = (r_clr == CLR_W'(CLR_DEPTH - 1));
    assign o_stat.phase    = r_phase;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_left  = r_out_l;
    assign o_out_right = r_out_r;

endmodule

// ----- rtl/pingpong_delay_and_comb_reverb_core.sv -----
// ----------------------------------------------------------------------------
// pingpong_delay_and_comb_reverb_core
// Stereo ping-pong delay with half-rate damped-comb and allpass reverb.
// ----------------------------------------------------------------------------
// After reset the core runs a clearing pass over its line memories, covering
// the larger of MAX_DELAY and the comb/allpass store depths (65536 entries
// at the defaults), before it accepts the first frame; configuration
// writes are taken throughout. A frame that skips the reverb is loaded and
// passes the delay write step and then the output step. A frame that runs it
// passes, after the delay write step and for each side in turn, through
// one shared comb unit of four steps and one allpass unit of two steps
// walking every line in turn on stores with one read and one write port;
// the reverb runs on every other frame. A finished result waits in an
// output register while the next frame is accepted.
`include "pingpong_delay_and_comb_reverb_core_defines.svh"

module pingpong_delay_and_comb_reverb_core import pdcr_pkg::*; #(
    parameter int MAX_DELAY   = P_MAX_DELAY,
    parameter int NUM_COMBS   = P_NUM_COMBS,
    parameter int NUM_ALLPASS = P_NUM_ALLPASS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [SEND_W-1:0] i_delay_send_left,
    input  logic signed [SEND_W-1:0] i_delay_send_right,
    input  logic signed [SEND_W-1:0] i_reverb_send_left,
    input  logic signed [SEND_W-1:0] i_reverb_send_right,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [SMP_W-1:0]  o_out_left,
    output logic signed [SMP_W-1:0]  o_out_right
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_accept;

    assign w_accept = i_in_valid && o_in_ready;

    // Sequencer
    pdcr_ctrl #(
        .NUM_COMBS   (NUM_COMBS),
        .NUM_ALLPASS (NUM_ALLPASS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath
    pdcr_datapath #(
        .MAX_DELAY   (MAX_DELAY),
        .NUM_COMBS   (NUM_COMBS),
        .NUM_ALLPASS (NUM_ALLPASS)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_stat              (w_stat),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_idx           (i_cfg_idx),
        .i_cfg_data          (i_cfg_data),
        .i_delay_send_left   (i_delay_send_left),
        .i_delay_send_right  (i_delay_send_right),
        .i_reverb_send_left  (i_reverb_send_left),
        .i_reverb_send_right (i_reverb_send_right),
        .i_out_ready         (i_out_ready),
        .o_out_valid         (o_out_valid),
        .o_out_left          (o_out_left),
        .o_out_right         (o_out_right)
    );

    // An accepted beat is followed by the delay write step
    `PDCR_ASSERT_NEXT(a_accept_then_dwr, w_accept, w_cmd.op == OP_DWR)
    // A new result only appears after an output load
    `PDCR_ASSERT_IMP(a_out_after_load, $rose(o_out_valid), $past(w_cmd.op == OP_OUT))
    // No beat is taken during the clearing pass
    `PDCR_ASSERT_IMP(a_no_accept_in_clear, w_cmd.op == OP_CLR, !o_in_ready)

endmodule
